@@ src/tsm_pkg.sv @@
// ----------------------------------------------------------------------------
// tsm_pkg
// Shared types, codes and constants for the step sequencer table modulator.
// ----------------------------------------------------------------------------
package tsm_pkg;

	localparam int MAX_STEPS_DEF = 16;

	localparam int LEVEL_W   = 8;
	localparam int VALUE_W   = 7;
	localparam int GAIN_W    = 5;
	localparam int COUNT_W   = 5;
	localparam int STEP_OUT_W = 4;
	localparam int ENTRY_W   = 4;
	localparam int OPCODE_W  = 2;

	localparam int S_TDATA_W = 16;
	localparam int S_TUSER_W = OPCODE_W;
	localparam int M_TDATA_W = 16;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 8;

	// dividend holds mapped * gain + offset_up, at most 127 * 31 + 127
	localparam int DIVIDEND_W  = 12;
	localparam int DIVISOR_W   = 5;
	localparam int DIV_STEP_N  = 3;
	localparam int DIV_ITERS   = DIVIDEND_W / DIV_STEP_N;

	typedef enum logic [OPCODE_W-1:0] {
		OP_TICK  = 2'd0,
		OP_WRITE = 2'd1,
		OP_QUERY = 2'd2,
		OP_SPARE = 2'd3
	} opcode_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ENABLE      = 3'd0,
		REG_STEP_COUNT  = 3'd1,
		REG_GAIN        = 3'd2,
		REG_OFFSET_UP   = 3'd3,
		REG_OFFSET_DOWN = 3'd4,
		REG_DIVISOR     = 3'd5,
		REG_RANGE_A     = 3'd6,
		REG_RANGE_B     = 3'd7
	} reg_index_t;

	// reset contents of the level table: an eight-entry ramp, repeated
	localparam logic [LEVEL_W-1:0] RAMP_LEVEL [8] = '{
		8'd0, 8'd36, 8'd73, 8'd109, 8'd146, 8'd182, 8'd219, 8'd255
	};

endpackage

@@ src/tsm_level_mem.sv @@
// ----------------------------------------------------------------------------
// tsm_level_mem
// Level table: synchronous single-write, single-read memory with per-entry
// valid bits; an entry never written reads as its reset ramp level.
// ----------------------------------------------------------------------------
module tsm_level_mem
	import tsm_pkg::*;
#(
	parameter int MAX_STEPS = MAX_STEPS_DEF,
	localparam int IDX_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [IDX_W-1:0]   wr_addr,
	input  logic [LEVEL_W-1:0] wr_data,
	input  logic               rd_en,
	input  logic [IDX_W-1:0]   rd_addr,
	output logic [LEVEL_W-1:0] rd_data
);

	logic [LEVEL_W-1:0] mem [MAX_STEPS];
	logic [MAX_STEPS-1:0] written_q;
	logic [LEVEL_W-1:0] rd_data_q;
	logic [2:0] ramp_idx;

	assign ramp_idx = 3'(rd_addr);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (wr_en) begin
			written_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (written_q[rd_addr]) begin
				rd_data_q <= mem[rd_addr];
			end else begin
				rd_data_q <= RAMP_LEVEL[ramp_idx];
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ src/tsm_divider.sv @@
// ----------------------------------------------------------------------------
// tsm_divider
// Iterative restoring divider, unsigned, several quotient bits per cycle.
// A divisor of zero divides by one.
// ----------------------------------------------------------------------------
module tsm_divider
	import tsm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int REM_W  = DIVISOR_W + 1;
	localparam int ITER_W = (DIV_ITERS > 1) ? $clog2(DIV_ITERS) : 1;

	logic                  busy_q;
	logic                  done_q;
	logic [ITER_W-1:0]     iter_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [REM_W-1:0]      rem_q;
	logic [REM_W-1:0]      den_q;
	logic [DIVIDEND_W-1:0] quo_nxt;
	logic [REM_W-1:0]      rem_nxt;

	always_comb begin
		quo_nxt = quo_q;
		rem_nxt = rem_q;
		for (int k = 0; k < DIV_STEP_N; k++) begin
			rem_nxt = {rem_nxt[REM_W-2:0], quo_nxt[DIVIDEND_W-1]};
			quo_nxt = {quo_nxt[DIVIDEND_W-2:0], 1'b0};
			if (rem_nxt >= den_q) begin
				rem_nxt    = rem_nxt - den_q;
				quo_nxt[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == ITER_W'(DIV_ITERS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= (divisor == '0) ? REM_W'(1) : REM_W'(divisor);
		end else if (busy_q) begin
			quo_q <= quo_nxt;
			rem_q <= rem_nxt;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ src/table_step_modulator.sv @@
// ----------------------------------------------------------------------------
// table_step_modulator
// Step sequencer with a level table, scaled and clamped output per request.
// ----------------------------------------------------------------------------
// Each request (tick, table write or query) returns one result: the scaled
// level of the current step and that step. The block works on one request at
// a time; from one acceptance to the next a request passes through the table
// write or step update, one read of the level memory, the level-by-span
// multiply, the mapping into the output range, the gain multiply, the divider
// (four iterations of three quotient bits each, then a completion flag) and
// the final clamp into the output register; the clamp waits while the
// previous result still sits in a full output register. A finished result
// waits in the output register while the next request is taken. The level
// table holds its reset ramp by per-entry valid bits, so no clearing pass
// follows reset. Configuration writes are taken at any time and belong
// between requests.
module table_step_modulator
	import tsm_pkg::*;
#(
	parameter int MAX_STEPS = MAX_STEPS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [S_TDATA_W-1:0]   s_tdata,   // entry_index[3:0], entry_level[11:4]
	input  logic [S_TUSER_W-1:0]   s_tuser,   // opcode[1:0]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [M_TDATA_W-1:0]   m_tdata,   // output_value[6:0], step_index[10:7]
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int IDX_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
	localparam int CW    = ($clog2(MAX_STEPS + 1) > COUNT_W) ? $clog2(MAX_STEPS + 1) + 1
	                                                          : COUNT_W + 1;
	localparam int PROD_W = LEVEL_W + VALUE_W;
	localparam int MAPD_W = PROD_W + 2;
	localparam int GPROD_W = VALUE_W + GAIN_W;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_READ = 7'b0000010,
		ST_MUL  = 7'b0000100,
		ST_MAP  = 7'b0001000,
		ST_GAIN = 7'b0010000,
		ST_DIV  = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

	state_t state_q;

	logic               enable_q;
	logic [COUNT_W-1:0] step_count_q;
	logic [GAIN_W-1:0]  gain_q;
	logic [VALUE_W-1:0] offset_up_q;
	logic [VALUE_W-1:0] offset_down_q;
	logic [DIVISOR_W-1:0] divisor_q;
	logic [VALUE_W-1:0] range_a_q;
	logic [VALUE_W-1:0] range_b_q;

	logic [IDX_W-1:0]   cur_step_q;
	logic               step_valid_q;

	logic [PROD_W-1:0]     lvl_prod_q;
	logic [VALUE_W-1:0]    mapped_q;
	logic                  neg_q;
	logic                  m_tvalid_q;
	logic [M_TDATA_W-1:0]  m_tdata_q;

	opcode_t            opcode;
	logic [ENTRY_W-1:0] entry_index;
	logic [LEVEL_W-1:0] entry_level;
	logic               s_req;
	logic               cfg_req;

	logic [VALUE_W-1:0] lo;
	logic [VALUE_W-1:0] hi;
	logic [VALUE_W-1:0] span;
	logic [CW-1:0]      cur_ext;
	logic [CW-1:0]      count_ext;
	logic [CW-1:0]      count_sat;
	logic [CW-1:0]      widx_ext;
	logic [CW-1:0]      step_ext;
	logic [CW-1:0]      new_count_ext;

	logic               mem_we;
	logic [IDX_W-1:0]   mem_rd_addr;
	logic [LEVEL_W-1:0] mem_rd_data;

	logic [MAPD_W-1:0]   map_num;
	logic [MAPD_W-1:0]   map_quo;
	logic [GPROD_W-1:0]  gain_prod;
	logic [DIVIDEND_W:0] num_pos;
	logic [DIVIDEND_W:0] num_mag;
	logic                div_start;
	logic                div_done;
	logic [DIVIDEND_W-1:0] div_quo;
	logic [VALUE_W-1:0]  clamped;
	logic                out_load;

	assign opcode      = opcode_t'(s_tuser[OPCODE_W-1:0]);
	assign entry_index = s_tdata[ENTRY_W-1:0];
	assign entry_level = s_tdata[ENTRY_W +: LEVEL_W];

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign s_req     = s_tvalid && s_tready;
	assign cfg_req   = cfg_valid && cfg_ready;

	assign lo   = (range_a_q < range_b_q) ? range_a_q : range_b_q;
	assign hi   = (range_a_q < range_b_q) ? range_b_q : range_a_q;
	assign span = hi - lo;

	assign cur_ext       = CW'(cur_step_q);
	assign count_ext     = CW'(step_count_q);
	assign count_sat     = (count_ext > CW'(MAX_STEPS)) ? CW'(MAX_STEPS) : count_ext;
	assign widx_ext      = CW'(entry_index);
	assign step_ext      = step_valid_q ? cur_ext : '0;
	assign new_count_ext = CW'(cfg_data[COUNT_W-1:0]);

	assign mem_we      = s_req && (opcode == OP_WRITE) && (widx_ext < CW'(MAX_STEPS));
	assign mem_rd_addr = step_valid_q ? cur_step_q : '0;

	tsm_level_mem #(
		.MAX_STEPS(MAX_STEPS)
	) u_level_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mem_we),
		.wr_addr (widx_ext[IDX_W-1:0]),
		.wr_data (entry_level),
		.rd_en   (state_q == ST_READ),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= 1'b1;
			step_count_q  <= COUNT_W'(8);
			gain_q        <= GAIN_W'(1);
			offset_up_q   <= '0;
			offset_down_q <= '0;
			divisor_q     <= DIVISOR_W'(1);
			range_a_q     <= '0;
			range_b_q     <= VALUE_W'(127);
		end else if (cfg_req) begin
			case (reg_index_t'(cfg_index))
				REG_ENABLE:      enable_q      <= cfg_data[0];
				REG_STEP_COUNT:  step_count_q  <= cfg_data[COUNT_W-1:0];
				REG_GAIN:        gain_q        <= cfg_data[GAIN_W-1:0];
				REG_OFFSET_UP:   offset_up_q   <= cfg_data[VALUE_W-1:0];
				REG_OFFSET_DOWN: offset_down_q <= cfg_data[VALUE_W-1:0];
				REG_DIVISOR:     divisor_q     <= cfg_data[DIVISOR_W-1:0];
				REG_RANGE_A:     range_a_q     <= cfg_data[VALUE_W-1:0];
				REG_RANGE_B:     range_b_q     <= cfg_data[VALUE_W-1:0];
				default: ;
			endcase
		end
	end

	// step state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_step_q   <= '0;
			step_valid_q <= 1'b0;
		end else if (cfg_req && (reg_index_t'(cfg_index) == REG_STEP_COUNT)) begin
			if (step_valid_q && (cur_ext >= new_count_ext)) begin
				step_valid_q <= 1'b0;
			end
		end else if (s_req && (opcode == OP_TICK) && enable_q && (count_sat != '0)) begin
			if (!step_valid_q || ((cur_ext + CW'(1)) >= count_sat)) begin
				cur_step_q <= '0;
			end else begin
				cur_step_q <= cur_step_q + 1'b1;
			end
			step_valid_q <= 1'b1;
		end
	end

	// mapped = lo + (level * span + 127) / 255, the divide by 255 done by reciprocal
	assign map_num   = MAPD_W'(lvl_prod_q) + MAPD_W'(127);
	assign map_quo   = (map_num + (map_num >> 8) + MAPD_W'(1)) >> 8;
	assign gain_prod = GPROD_W'(mapped_q) * GPROD_W'(gain_q);
	assign num_pos   = (DIVIDEND_W + 1)'(gain_prod) + (DIVIDEND_W + 1)'(offset_up_q);
	assign num_mag   = num_pos - (DIVIDEND_W + 1)'(offset_down_q);
	assign div_start = (state_q == ST_GAIN);

	tsm_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (num_mag[DIVIDEND_W-1:0]),
		.divisor  (divisor_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		if (neg_q || (div_quo < DIVIDEND_W'(lo))) begin
			clamped = lo;
		end else if (div_quo > DIVIDEND_W'(hi)) begin
			clamped = hi;
		end else begin
			clamped = div_quo[VALUE_W-1:0];
		end
	end

	assign out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (s_req)    state_q <= ST_READ;
				ST_READ:               state_q <= ST_MUL;
				ST_MUL:                state_q <= ST_MAP;
				ST_MAP:                state_q <= ST_GAIN;
				ST_GAIN:               state_q <= ST_DIV;
				ST_DIV:  if (div_done) state_q <= ST_DONE;
				ST_DONE: if (out_load) state_q <= ST_IDLE;
				default:               state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			lvl_prod_q <= PROD_W'(mem_rd_data) * PROD_W'(span);
		end
		if (state_q == ST_MAP) begin
			mapped_q <= lo + map_quo[VALUE_W-1:0];
		end
		if (state_q == ST_GAIN) begin
			neg_q <= (num_pos < (DIVIDEND_W + 1)'(offset_down_q));
		end
		if (out_load) begin
			m_tdata_q <= M_TDATA_W'({step_ext[STEP_OUT_W-1:0], clamped});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_accept_starts_read: assert property (@(posedge clk) disable iff (!arst_n)
		s_req |=> state_q == ST_READ)
		else $error("accepted request did not start a table read");

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide phase");

	a_step_in_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		step_valid_q |-> cur_ext < count_ext)
		else $error("current step beyond step count");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && m_tvalid_q && !m_tready |=> state_q == ST_DONE)
		else $error("result dropped while output register full");

endmodule
